FILE: rtl/core/hjbp_pkg.sv
package hjbp_pkg;

   localparam int SLOTS_PER_BUCKET_DEF = 2;
   localparam int HEAD_BUCKETS_DEF     = 1024;
   localparam int POOL_BUCKETS_DEF     = 1024;

   localparam int KEY_W      = 64;
   localparam int COUNT_W    = 12;
   localparam int COUNT_MAX  = 4095;
   localparam int BBITS_W    = 4;
   localparam int HASH_IN_W  = 15;
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 80;
   localparam int CSR_DATA_W = 4;

   localparam logic CSR_BUCKET_BITS     = 1'b0;
   localparam logic CSR_MATCH_VALUE_TOO = 1'b1;

   localparam logic OP_BUILD = 1'b0;
   localparam logic OP_PROBE = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0] value;
      logic [KEY_W-1:0] key;
   } tuple_type;

endpackage

FILE: rtl/core/hjbp_ram.sv
module hjbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/core/hjbp_hash.sv
module hjbp_hash #(
   parameter int HEAD_BUCKETS = hjbp_pkg::HEAD_BUCKETS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [hjbp_pkg::KEY_W-1:0]        key,
   input  logic [hjbp_pkg::BBITS_W-1:0]      bucket_bits,
   output logic                              done,
   output logic [$clog2(HEAD_BUCKETS)-1:0]   index
);
   import hjbp_pkg::*;

   localparam int HW = $clog2(HEAD_BUCKETS);
   localparam longint RECIP = (64'd1 << 32) / HEAD_BUCKETS;
   localparam int PROD_W = HASH_IN_W + 32;
   localparam int REM_W = 18;

   logic [HASH_IN_W-1:0] x_ff, x_in;
   logic [PROD_W-1:0]    prod_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [2:0]           v_ff;
   logic [HASH_IN_W-1:0] mask;
   logic [HASH_IN_W-1:0] quot;
   logic [REM_W-1:0]     qh;

   // Reduce modulo HEAD_BUCKETS by a reciprocal multiply; the estimate is
   // low by at most one, so one compare and subtract corrects it.
   always_comb begin
      mask = HASH_IN_W'((32'd1 << bucket_bits) - 32'd1);
      x_in = key[HASH_IN_W-1:0] & mask;
      quot = prod_ff[PROD_W-1:32];
      qh   = REM_W'(34'(quot) * 34'(HEAD_BUCKETS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], start};
      end
      if (start) begin
         x_ff <= x_in;
      end
      prod_ff <= PROD_W'(x_ff) * PROD_W'(32'(RECIP));
      rem_ff  <= REM_W'(x_ff) - qh;
   end

   assign done  = v_ff[2];
   assign index = (rem_ff >= REM_W'(HEAD_BUCKETS)) ?
                  HW'(rem_ff - REM_W'(HEAD_BUCKETS)) : HW'(rem_ff);
endmodule

FILE: rtl/core/hjbp_match.sv
module hjbp_match #(
   parameter int CW = 12
) (
   input  logic                   clock,
   input  logic                   clear,
   input  logic                   enable,
   input  logic                   match_value_too,
   input  hjbp_pkg::tuple_type    slot,
   input  hjbp_pkg::tuple_type    probe,
   output logic [CW-1:0]          count
);
   import hjbp_pkg::*;

   logic [CW-1:0] count_ff;
   logic          hit;

   assign hit = (slot.key == probe.key) &&
                (!match_value_too || (slot.value == probe.value));

   always_ff @(posedge clock) begin
      if (clear) begin
         count_ff <= '0;
      end else if (enable && hit) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   assign count = count_ff;
endmodule

FILE: rtl/core/hash_join_build_probe_top.sv
// Chained-bucket hash join engine. Each transfer on the req_ channel is one
// tuple: req_tuser is the opcode (build or probe), req_tdata the key and
// value, req_tlast the end of a batch. Every tuple gives exactly one rsp_
// transfer with a status, the match count of a probe and the running batch
// total. A new tuple is taken only after the last one is finished and its
// response is loaded; time spent waiting for rsp_tready delays it. A probe
// reads and compares one stored slot at a time through the shared compare
// unit and the single read port of each table memory, and also reads the
// metadata of each overflow bucket in its chain. The hash is a reciprocal
// modulo with registered input, product and remainder. After reset the
// head bucket table is cleared, one bucket per cycle, before the first
// tuple is taken; csr_ writes are taken at any time.
module hash_join_build_probe_top #(
   parameter int SLOTS_PER_BUCKET = hjbp_pkg::SLOTS_PER_BUCKET_DEF,
   parameter int HEAD_BUCKETS     = hjbp_pkg::HEAD_BUCKETS_DEF,
   parameter int POOL_BUCKETS     = hjbp_pkg::POOL_BUCKETS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hjbp_pkg::REQ_DATA_W-1:0]   req_tdata,  // key, value
   input  logic                              req_tuser,  // opcode
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hjbp_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // status, match_count,
                                                         // batch_total, zero pad
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [hjbp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hjbp_pkg::*;

   localparam int HW  = $clog2(HEAD_BUCKETS);
   localparam int PW  = (POOL_BUCKETS > 1) ? $clog2(POOL_BUCKETS) : 1;
   localparam int LW  = $clog2(POOL_BUCKETS + 1);
   localparam int FW  = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int HAW = $clog2(HEAD_BUCKETS * SLOTS_PER_BUCKET);
   localparam int PAW = (POOL_BUCKETS * SLOTS_PER_BUCKET > 1) ?
                        $clog2(POOL_BUCKETS * SLOTS_PER_BUCKET) : 1;
   localparam int CW  = $clog2(SLOTS_PER_BUCKET * (POOL_BUCKETS + 1) + 1);
   localparam int MW  = LW + FW;

   // One-hot sequencer states.
   typedef enum logic [11:0] {
      ST_CLEAR = 12'b000000000001,
      ST_IDLE  = 12'b000000000010,
      ST_HASH  = 12'b000000000100,
      ST_HRD   = 12'b000000001000,
      ST_HMETA = 12'b000000010000,
      ST_BPOOL = 12'b000000100000,
      ST_ALLOC = 12'b000001000000,
      ST_SRD   = 12'b000010000000,
      ST_SCMP  = 12'b000100000000,
      ST_CHK   = 12'b001000000000,
      ST_PMETA = 12'b010000000000,
      ST_FIN   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic [BBITS_W-1:0] bucket_bits_ff;
   logic               match_value_too_ff;

   tuple_type  tup_ff;
   logic       op_ff;
   logic       last_ff;
   logic [HW-1:0] clr_ff, clr_in;
   logic [HW-1:0] h_ff, h_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [LW-1:0] link_ff, link_in;   // head link, then chain cursor
   logic [LW-1:0] plink_ff, plink_in;
   logic [PW-1:0] p_ff, p_in;
   logic [FW-1:0] i_ff, i_in;
   logic          scan_pool_ff, scan_pool_in;
   logic          status_ff, status_in;
   logic [LW-1:0] used_ff, used_in;
   logic [KEY_W-1:0] total_ff;

   logic          rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Memory ports.
   logic           hkv_we, pkv_we, hm_we, pm_we;
   logic [HAW-1:0] hkv_waddr, hkv_raddr;
   logic [PAW-1:0] pkv_waddr, pkv_raddr;
   logic [HW-1:0]  hm_waddr;
   logic [MW-1:0]  hm_wdata, hm_rdata, pm_wdata, pm_rdata;
   logic [PW-1:0]  pm_waddr, pm_raddr;
   tuple_type      hkv_rdata, pkv_rdata, slot;

   logic          hash_done;
   logic [HW-1:0] hash_index;
   logic          accept;
   logic [CW-1:0] count;
   logic [KEY_W:0] sum;
   logic [KEY_W-1:0] total_new;
   logic [31:0]   count32;
   logic [PW-1:0] cur_idx;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign cur_idx    = PW'(link_ff - LW'(1));

   hjbp_hash #(.HEAD_BUCKETS(HEAD_BUCKETS)) u_hash (
      .clock(clock), .reset(reset), .start(accept),
      .key(req_tdata[KEY_W-1:0]), .bucket_bits(bucket_bits_ff),
      .done(hash_done), .index(hash_index)
   );

   hjbp_ram #(.WIDTH(2*KEY_W), .DEPTH(HEAD_BUCKETS*SLOTS_PER_BUCKET)) u_head_kv (
      .clock(clock), .we(hkv_we), .waddr(hkv_waddr), .wdata(tup_ff),
      .raddr(hkv_raddr), .rdata(hkv_rdata)
   );

   hjbp_ram #(.WIDTH(2*KEY_W), .DEPTH(POOL_BUCKETS*SLOTS_PER_BUCKET)) u_pool_kv (
      .clock(clock), .we(pkv_we), .waddr(pkv_waddr), .wdata(tup_ff),
      .raddr(pkv_raddr), .rdata(pkv_rdata)
   );

   hjbp_ram #(.WIDTH(MW), .DEPTH(HEAD_BUCKETS)) u_head_meta (
      .clock(clock), .we(hm_we), .waddr(hm_waddr), .wdata(hm_wdata),
      .raddr(h_ff), .rdata(hm_rdata)
   );

   hjbp_ram #(.WIDTH(MW), .DEPTH(POOL_BUCKETS)) u_pool_meta (
      .clock(clock), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
      .raddr(pm_raddr), .rdata(pm_rdata)
   );

   assign slot = scan_pool_ff ? pkv_rdata : hkv_rdata;

   hjbp_match #(.CW(CW)) u_match (
      .clock(clock), .clear(state_ff == ST_HASH),
      .enable(state_ff == ST_SCMP), .match_value_too(match_value_too_ff),
      .slot(slot), .probe(tup_ff), .count(count)
   );

   // Saturating batch total including this probe's matches.
   assign sum       = (KEY_W+1)'(total_ff) + (KEY_W+1)'(count);
   assign total_new = sum[KEY_W] ? {KEY_W{1'b1}} : sum[KEY_W-1:0];
   assign count32   = 32'(count);

   // Slot read addresses follow the scan index; pool metadata reads follow the
   // chain cursor.
   assign hkv_raddr = HAW'(h_ff) * HAW'(SLOTS_PER_BUCKET) + HAW'(i_ff);
   assign pkv_raddr = PAW'(p_ff) * PAW'(SLOTS_PER_BUCKET) + PAW'(i_ff);
   assign pm_raddr  = cur_idx;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      h_in         = h_ff;
      fill_in      = fill_ff;
      link_in      = link_ff;
      plink_in     = plink_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      scan_pool_in = scan_pool_ff;
      status_in    = status_ff;
      used_in      = used_ff;
      hkv_we       = 1'b0;
      pkv_we       = 1'b0;
      hm_we        = 1'b0;
      pm_we        = 1'b0;
      hkv_waddr    = HAW'(h_ff) * HAW'(SLOTS_PER_BUCKET) + HAW'(fill_ff);
      pkv_waddr    = PAW'(p_ff) * PAW'(SLOTS_PER_BUCKET) + PAW'(fill_ff);
      hm_waddr     = h_ff;
      hm_wdata     = {link_ff, fill_ff + FW'(1)};
      pm_waddr     = p_ff;
      pm_wdata     = {plink_ff, fill_ff + FW'(1)};
      case (state_ff)
         ST_CLEAR: begin
            hm_we    = 1'b1;
            hm_waddr = clr_ff;
            hm_wdata = '0;
            clr_in   = clr_ff + HW'(1);
            if (clr_ff == HW'(HEAD_BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               status_in = 1'b0;
               state_in  = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               h_in     = hash_index;
               state_in = ST_HRD;
            end
         end
         ST_HRD: begin
            state_in = ST_HMETA;
         end
         ST_HMETA: begin
            fill_in      = hm_rdata[FW-1:0];
            link_in      = hm_rdata[MW-1:FW];
            i_in         = '0;
            scan_pool_in = 1'b0;
            if (op_ff == OP_BUILD) begin
               if (hm_rdata[FW-1:0] < FW'(SLOTS_PER_BUCKET)) begin
                  hkv_we    = 1'b1;
                  hkv_waddr = HAW'(h_ff) * HAW'(SLOTS_PER_BUCKET) +
                              HAW'(hm_rdata[FW-1:0]);
                  hm_we     = 1'b1;
                  hm_wdata  = {hm_rdata[MW-1:FW], hm_rdata[FW-1:0] + FW'(1)};
                  state_in  = ST_FIN;
               end else if (hm_rdata[MW-1:FW] != '0) begin
                  state_in = ST_CHK;
               end else begin
                  state_in = ST_ALLOC;
               end
            end else if (hm_rdata[FW-1:0] != '0) begin
               state_in = ST_SRD;
            end else begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            // Metadata of the pool bucket at the cursor is being read.
            p_in = cur_idx;
            if (link_ff == '0) begin
               state_in = ST_FIN;
            end else if (op_ff == OP_BUILD) begin
               state_in = ST_BPOOL;
            end else begin
               state_in = ST_PMETA;
            end
         end
         ST_BPOOL: begin
            fill_in  = pm_rdata[FW-1:0];
            plink_in = pm_rdata[MW-1:FW];
            if (pm_rdata[FW-1:0] < FW'(SLOTS_PER_BUCKET)) begin
               pkv_we    = 1'b1;
               pkv_waddr = PAW'(p_ff) * PAW'(SLOTS_PER_BUCKET) +
                           PAW'(pm_rdata[FW-1:0]);
               pm_we     = 1'b1;
               pm_wdata  = {pm_rdata[MW-1:FW], pm_rdata[FW-1:0] + FW'(1)};
               state_in  = ST_FIN;
            end else begin
               fill_in  = FW'(SLOTS_PER_BUCKET);
               state_in = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            // Splice a fresh pool bucket in right after the head bucket.
            if (used_ff >= LW'(POOL_BUCKETS)) begin
               status_in = 1'b1;
            end else begin
               pkv_we    = 1'b1;
               pkv_waddr = PAW'(used_ff) * PAW'(SLOTS_PER_BUCKET);
               pm_we     = 1'b1;
               pm_waddr  = PW'(used_ff);
               pm_wdata  = {link_ff, FW'(1)};
               hm_we     = 1'b1;
               hm_wdata  = {used_ff + LW'(1), FW'(SLOTS_PER_BUCKET)};
               used_in   = used_ff + LW'(1);
            end
            state_in = ST_FIN;
         end
         ST_PMETA: begin
            fill_in      = pm_rdata[FW-1:0];
            plink_in     = pm_rdata[MW-1:FW];
            i_in         = '0;
            scan_pool_in = 1'b1;
            if (pm_rdata[FW-1:0] != '0) begin
               state_in = ST_SRD;
            end else begin
               link_in  = pm_rdata[MW-1:FW];
               state_in = ST_CHK;
            end
         end
         ST_SRD: begin
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            i_in = i_ff + FW'(1);
            if ((i_ff + FW'(1)) < fill_ff) begin
               state_in = ST_SRD;
            end else begin
               if (scan_pool_ff) begin
                  link_in = plink_ff;
               end
               state_in = ST_CHK;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_CLEAR;
         clr_ff             <= '0;
         used_ff            <= '0;
         total_ff           <= '0;
         rsp_valid_ff       <= 1'b0;
         bucket_bits_ff     <= BBITS_W'(10);
         match_value_too_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         used_ff  <= used_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BUCKET_BITS:     bucket_bits_ff     <= csr_wdata;
               CSR_MATCH_VALUE_TOO: match_value_too_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if ((state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
            if (op_ff == OP_PROBE) begin
               total_ff <= last_ff ? '0 : total_new;
            end else if (last_ff) begin
               total_ff <= '0;
            end
         end
      end
      h_ff         <= h_in;
      fill_ff      <= fill_in;
      link_ff      <= link_in;
      plink_ff     <= plink_in;
      p_ff         <= p_in;
      i_ff         <= i_in;
      scan_pool_ff <= scan_pool_in;
      status_ff    <= status_in;
      if (accept) begin
         tup_ff  <= req_tdata;
         op_ff   <= req_tuser;
         last_ff <= req_tlast;
      end
      if ((state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready)) begin
         if (op_ff == OP_PROBE) begin
            rsp_data_ff <= {3'b000, total_new,
                            (count32 > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                       : count32[COUNT_W-1:0],
                            1'b0};
         end else begin
            rsp_data_ff <= {3'b000, total_ff, COUNT_W'(0), status_ff};
         end
      end
   end

   // The pool never hands out more buckets than it has.
   assert property (@(posedge clock) disable iff (reset)
      used_ff <= LW'(POOL_BUCKETS))
      else $error("pool allocation count out of range");

   // No tuple is taken while the head table is being cleared.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("tuple taken during table clear");

   // A drop is only reported for a build, with no matches.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[COUNT_W:1] == '0))
      else $error("dropped build reports matches");

   // A new result is only loaded once the previous one was taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_data_ff))
      else $error("result overwritten before transfer");
endmodule
